// ----- rtl/dpd_pkg.sv -----
// Shared types and constants for the depth pixel deprojection block.
// Pixel and point transaction structs, register indexes, pipeline and divider sizes.
// No dependencies.
`default_nettype none

package dpd_pkg;

  // Pipeline layout: offset, multiply, round-bias add, divider stages, output.
  localparam int DIV_DIGIT  = 4;
  localparam int DIVIDEND_W = 44;
  localparam int DIV_STAGES = DIVIDEND_W / DIV_DIGIT;
  localparam int DIV_FIRST  = 3;
  localparam int STAGES     = DIV_FIRST + DIV_STAGES + 1;

  localparam int REG_INDEX_W = 4;
  localparam int REG_DATA_W  = 16;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_ROI_LEFT   = 4'd0,
    REG_ROI_RIGHT  = 4'd1,
    REG_ROI_TOP    = 4'd2,
    REG_ROI_BOTTOM = 4'd3,
    REG_CENTER_X   = 4'd4,
    REG_CENTER_Y   = 4'd5,
    REG_FOCAL_X    = 4'd6,
    REG_FOCAL_Y    = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] depth_mm;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [23:0]        point_z;
    logic [23:0]        packed_color;
  } point_t;

endpackage

`default_nettype wire

// ----- rtl/dpd_divider.sv -----
// Pipelined restoring divider, one radix-16 quotient digit per stage.
// Depends on dpd_pkg for the dividend width and stage count.
`default_nettype none

module dpd_divider (
  input  wire logic                                 clk,
  input  wire logic [dpd_pkg::DIV_STAGES-1:0]       adv,
  input  wire logic [dpd_pkg::DIVIDEND_W-1:0]       dividend,
  input  wire logic [15:0]                          divisor,
  output logic      [dpd_pkg::DIVIDEND_W-1:0]       quotient
);

  // Partial remainder and a shift word: dividend bits leave at the top,
  // quotient bits enter at the bottom.
  typedef struct packed {
    logic [15:0]                    rem;
    logic [dpd_pkg::DIVIDEND_W-1:0] acc;
  } div_state_t;

  function automatic div_state_t div_digit(div_state_t st, logic [15:0] d);
    div_state_t  r;
    logic [16:0] t;
    logic        ge;
    r = st;
    for (int i = 0; i < dpd_pkg::DIV_DIGIT; i++) begin
      t     = {r.rem, r.acc[dpd_pkg::DIVIDEND_W-1]};
      ge    = (t >= {1'b0, d});
      r.rem = ge ? 16'(t - {1'b0, d}) : t[15:0];
      r.acc = {r.acc[dpd_pkg::DIVIDEND_W-2:0], ge};
    end
    return r;
  endfunction

  div_state_t seed;
  div_state_t stage [dpd_pkg::DIV_STAGES];

  assign seed = {16'd0, dividend};

  // First digit from the fresh dividend
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      stage[0] <= div_digit(seed, divisor);
    end
  end

  // Remaining digits, one per stage
  for (genvar k = 1; k < dpd_pkg::DIV_STAGES; k++) begin : g_digit
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        stage[k] <= div_digit(stage[k-1], divisor);
      end
    end
  end

  assign quotient = stage[dpd_pkg::DIV_STAGES-1].acc;

endmodule

`default_nettype wire

// ----- rtl/depth_pixel_deprojection.sv -----
// Depth pixel deprojection top level: config registers, region test, pipeline.
// Depends on dpd_pkg and dpd_divider.
//
// Turns each depth pixel inside the inclusive region of interest into a colored
// 3D point using pinhole intrinsics; pixels outside the region are consumed and
// produce no point. The block takes one pixel per cycle unless back-pressure has
// filled every stage. Between pixel and point transaction: one stage each for the
// center offset, the 16x16 multiply and the rounding bias, eleven stages of the
// radix-16 divider that works through the 44-bit dividend four quotient bits at
// a time, and the saturating output register. Each stage holds its item only
// while the stage after it is full and stalled, so bubbles close up under
// back-pressure. Coordinates are millimetres with 8 fractional bits, rounded
// to nearest with ties away from zero. Write configuration only while idle.
`default_nettype none

module depth_pixel_deprojection (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dpd_pkg::REG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dpd_pkg::REG_DATA_W-1:0]    cfg_data,
  input  wire logic                              pixel_valid,
  output logic                                   pixel_ready,
  input  wire dpd_pkg::pixel_t                   pixel,
  output logic                                   point_valid,
  input  wire logic                              point_ready,
  output dpd_pkg::point_t                        point
);

  localparam int NS   = dpd_pkg::STAGES;
  localparam int DW   = dpd_pkg::DIVIDEND_W;
  localparam int DLST = dpd_pkg::DIV_FIRST + dpd_pkg::DIV_STAGES - 1;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [15:0] depth;
    logic [23:0] color;
  } side_t;

  // Configuration registers
  logic [11:0] roi_left, roi_right, roi_top, roi_bottom;
  logic [15:0] center_x, center_y, focal_x, focal_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left   <= 12'd0;
      roi_right  <= 12'd4095;
      roi_top    <= 12'd0;
      roi_bottom <= 12'd4095;
      center_x   <= 16'd10240;
      center_y   <= 16'd5760;
      focal_x    <= 16'd10240;
      focal_y    <= 16'd10240;
    end else if (cfg_we) begin
      case (cfg_index)
        dpd_pkg::REG_ROI_LEFT:   roi_left   <= cfg_data[11:0];
        dpd_pkg::REG_ROI_RIGHT:  roi_right  <= cfg_data[11:0];
        dpd_pkg::REG_ROI_TOP:    roi_top    <= cfg_data[11:0];
        dpd_pkg::REG_ROI_BOTTOM: roi_bottom <= cfg_data[11:0];
        dpd_pkg::REG_CENTER_X:   center_x   <= cfg_data;
        dpd_pkg::REG_CENTER_Y:   center_y   <= cfg_data;
        dpd_pkg::REG_FOCAL_X:    focal_x    <= cfg_data;
        dpd_pkg::REG_FOCAL_Y:    focal_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Treat a zero focal length as one
  logic [15:0] div_x, div_y;
  assign div_x = (focal_x == 16'd0) ? 16'd1 : focal_x;
  assign div_y = (focal_y == 16'd0) ? 16'd1 : focal_y;

  // Stage valid bits and the ready chain; a stage loads when empty or draining
  logic [NS-1:0] valid;
  logic [NS:0]   rdy;

  assign rdy[NS] = point_ready;
  for (genvar s = 0; s < NS; s++) begin : g_rdy
    assign rdy[s] = !valid[s] || rdy[s+1];
  end

  assign pixel_ready = rdy[0];
  assign point_valid = valid[NS-1];

  // Region test; drop pixels outside it at the first stage
  logic in_roi;
  assign in_roi = (pixel.column >= roi_left) && (pixel.column <= roi_right) &&
                  (pixel.row >= roi_top) && (pixel.row <= roi_bottom);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid[0] <= pixel_valid && in_roi;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid[s] <= valid[s-1];
      end
    end
  end

  // Stage 0: center offset in sixteenths, as sign and magnitude
  logic [15:0] pos_x, pos_y;
  logic        neg_x, neg_y;
  logic [15:0] mag_x, mag_y, s0_mag_x, s0_mag_y;
  side_t       side [NS-1];

  assign pos_x = {pixel.column, 4'd0};
  assign pos_y = {pixel.row, 4'd0};
  assign neg_x = pos_x < center_x;
  assign neg_y = pos_y < center_y;
  assign mag_x = neg_x ? 16'(center_x - pos_x) : 16'(pos_x - center_x);
  assign mag_y = neg_y ? 16'(center_y - pos_y) : 16'(pos_y - center_y);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_mag_x      <= mag_x;
      s0_mag_y      <= mag_y;
      side[0].neg_x <= neg_x;
      side[0].neg_y <= neg_y;
      side[0].depth <= pixel.depth_mm;
      side[0].color <= {pixel.red, pixel.green, pixel.blue};
    end
  end

  // Carry sign, depth and color alongside the datapath
  for (genvar s = 1; s < NS - 1; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        side[s] <= side[s-1];
      end
    end
  end

  // Stage 1: offset times depth
  logic [31:0] prod_x, prod_y;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod_x <= 32'(s0_mag_x) * 32'(side[0].depth);
      prod_y <= 32'(s0_mag_y) * 32'(side[0].depth);
    end
  end

  // Stage 2: scale by 256 and add half the divisor for rounding
  logic [DW-1:0] dvd_x, dvd_y;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dvd_x <= {4'd0, prod_x, 8'd0} + DW'(div_x[15:1]);
      dvd_y <= {4'd0, prod_y, 8'd0} + DW'(div_y[15:1]);
    end
  end

  // Divider stages
  logic [DW-1:0] quot_x, quot_y;

  dpd_divider u_div_x (
    .clk      (clk),
    .adv      (rdy[DLST:dpd_pkg::DIV_FIRST]),
    .dividend (dvd_x),
    .divisor  (div_x),
    .quotient (quot_x)
  );

  dpd_divider u_div_y (
    .clk      (clk),
    .adv      (rdy[DLST:dpd_pkg::DIV_FIRST]),
    .dividend (dvd_y),
    .divisor  (div_y),
    .quotient (quot_y)
  );

  // Apply sign and saturate to the signed 32-bit range
  function automatic logic [31:0] sat_axis(logic [DW-1:0] q, logic neg);
    logic [31:0] r;
    if (neg) begin
      if ((q[DW-1:32] != '0) || (q[31] && (q[30:0] != '0))) begin
        r = 32'h8000_0000;
      end else begin
        r = 32'(33'd0 - {1'b0, q[31:0]});
      end
    end else begin
      if (q[DW-1:31] != '0) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = {1'b0, q[30:0]};
      end
    end
    return r;
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      point.point_x      <= sat_axis(quot_x, side[NS-2].neg_x);
      point.point_y      <= sat_axis(quot_y, side[NS-2].neg_y);
      point.point_z      <= {side[NS-2].depth, 8'd0};
      point.packed_color <= side[NS-2].color;
    end
  end

  // A stalled input side means every stage is full and the output is blocked
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> ((&valid) && !point_ready))
    else $error("input stalled while pipeline has a free stage");

  // An in-region pixel transaction always lands in the first stage
  a_roi_enters: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready && in_roi) |=> valid[0])
    else $error("accepted in-region pixel lost at entry");

  // A held stage keeps its item
  for (genvar s = 0; s < NS; s++) begin : g_hold_chk
    a_stage_hold: assert property (@(posedge clk) disable iff (rst)
      (valid[s] && !rdy[s]) |=> valid[s])
      else $error("stalled stage dropped its item");
  end

  // Depth scaling leaves the low byte of z clear
  a_z_scaled: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> (point.point_z[7:0] == 8'd0))
    else $error("point z is not depth times 256");

endmodule

`default_nettype wire
